>>> design/hashed_key_value_table_linear_probe_macros.svh
// Assertion helpers for the key/value table checker.
`ifndef HASHED_KEY_VALUE_TABLE_LINEAR_PROBE_MACROS_SVH
`define HASHED_KEY_VALUE_TABLE_LINEAR_PROBE_MACROS_SVH

// Assert that a property holds whenever reset is low.
`define HKV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert that a property holds even while reset is high.
`define HKV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/hkv_pkg.sv
package hkv_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_NULL      = 3'd4;

  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] name_low;
    logic [55:0] name_high;
    logic [4:0]  name_length;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_value;
    logic [6:0]  live_entries;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture request, start key trim
    logic trim_step;  // scan one key byte for terminator
    logic hash_step;  // fold one key byte into the hash
    logic home;       // form home slot from hash
    logic reduce;     // one conditional subtract of the modulo
    logic rd;         // issue slot read at probe pointer
    logic advance;    // step probe pointer
    logic note_tomb;  // remember current slot as first tombstone
    logic wr_ins;     // write key/value at target slot
    logic wr_upd;     // write value at current slot
    logic wr_del;     // tombstone current slot
    logic set_rsp;    // latch response
    logic [2:0] rsp_status;
    logic rsp_found;  // response carries read value
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] func;
    logic value_zero;
    logic too_long;
    logic full;
    logic trim_done;
    logic hash_done;
    logic reduce_done;
    logic slot_live;
    logic slot_tomb;
    logic key_match;
    logic have_tomb;
    logic probe_done;  // every slot visited
  } sts_t;

endpackage

>>> design/hkv_ram.sv
module hkv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/hkv_ctrl.sv
module hkv_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  hkv_pkg::sts_t  sts,
  output hkv_pkg::cmd_t  cmd
);
  import hkv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIM, S_HASH, S_HOME, S_REDUCE, S_READ, S_WAIT, S_CHECK, S_RESP
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    cmd = '0;
    cmd.rsp_status = ST_NOT_FOUND;
    case (state)
      S_IDLE:   cmd.load = in_valid && !out_valid;
      S_TRIM:   cmd.trim_step = 1'b1;
      S_HASH:   cmd.hash_step = 1'b1;
      S_HOME:   cmd.home = 1'b1;
      S_REDUCE: cmd.reduce = 1'b1;
      S_READ:   cmd.rd = 1'b1;
      S_WAIT:   cmd.rd = 1'b0;
      S_CHECK: begin
        if (sts.func == FUNC_INSERT) begin
          if (sts.slot_live) begin
            if (sts.key_match) begin
              cmd.wr_upd = 1'b1;
              cmd.set_rsp = 1'b1;
              cmd.rsp_status = ST_OK;
            end else if (sts.probe_done) begin
              cmd.set_rsp = 1'b1;
              cmd.rsp_status = ST_FULL;
            end else begin
              cmd.advance = 1'b1;
            end
          end else if (sts.slot_tomb) begin
            cmd.note_tomb = !sts.have_tomb;
            if (sts.probe_done) begin
              cmd.set_rsp = 1'b1;
              cmd.rsp_status = ST_FULL;
            end else begin
              cmd.advance = 1'b1;
            end
          end else begin
            cmd.wr_ins = 1'b1;
            cmd.set_rsp = 1'b1;
            cmd.rsp_status = ST_OK;
          end
        end else begin
          if (!sts.slot_live && !sts.slot_tomb) begin
            cmd.set_rsp = 1'b1;
          end else if (sts.slot_live && sts.key_match) begin
            cmd.set_rsp = 1'b1;
            cmd.rsp_status = ST_OK;
            cmd.rsp_found = (sts.func == FUNC_LOOKUP);
            cmd.wr_del = (sts.func == FUNC_DELETE);
          end else if (sts.probe_done) begin
            cmd.set_rsp = 1'b1;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      S_RESP: begin
        cmd.set_rsp = 1'b1;
        if (sts.func == FUNC_INSERT) begin
          if (sts.value_zero) begin
            cmd.rsp_status = ST_NULL;
          end else if (sts.too_long) begin
            cmd.rsp_status = ST_TOO_LONG;
          end else begin
            cmd.rsp_status = ST_FULL;
          end
        end
      end
      default: cmd.rsp_status = ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (sts.trim_done) begin
            if ((sts.func == FUNC_INSERT && (sts.value_zero || sts.too_long || sts.full))
                || (sts.func != FUNC_INSERT && (sts.too_long
                    || (sts.func != FUNC_LOOKUP && sts.func != FUNC_DELETE)))) begin
              state <= S_RESP;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (sts.hash_done) begin
            state <= S_HOME;
          end
        end
        S_HOME:   state <= S_REDUCE;
        S_REDUCE: begin
          if (sts.reduce_done) begin
            state <= S_READ;
          end
        end
        S_READ:   state <= S_WAIT;
        S_WAIT:   state <= S_CHECK;
        S_CHECK: begin
          if (cmd.set_rsp) begin
            state <= S_IDLE;
            out_valid <= 1'b1;
          end else begin
            state <= S_READ;
          end
        end
        S_RESP: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/hkv_dp.sv
module hkv_dp #(
  parameter int SLOTS = 64,
  parameter int KEY_BYTES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  hkv_pkg::req_t  req,
  input  hkv_pkg::cmd_t  cmd,
  output hkv_pkg::sts_t  sts,
  output hkv_pkg::rsp_t  rsp
);
  import hkv_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = 5;
  localparam int SCAN_BYTES = 15;  // every byte the name fields can carry
  localparam logic [LW-1:0] MAX_LEN = LW'(KEY_BYTES - 1);

  req_t r;
  logic [119:0] key;
  logic [LW-1:0] len;
  logic [LW-1:0] idx;
  logic [31:0] hash;
  logic [31:0] rem;
  logic [4:0] sh;
  logic [63:0] div_sh;
  logic [AW-1:0] ptr;
  logic [AW-1:0] tomb;
  logic have_tomb;
  logic [CW-1:0] visited;
  logic [CW-1:0] live_count;
  logic [SLOTS-1:0] live;
  logic [SLOTS-1:0] tombs;
  logic too_long;
  logic [2:0] rsp_status;
  logic [63:0] rsp_value;
  logic [63:0] rd_value;
  logic [63:0] rd_klo;
  logic [55:0] rd_khi;
  logic [7:0] cur_byte;
  logic [31:0] hash_x;
  logic [31:0] rem_sub;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] ptr_inc;
  logic we_key;
  logic we_val;

  assign cur_byte = key[idx*8 +: 8];
  assign hash_x = hash ^ {24'd0, cur_byte};
  // Restoring modulo: one shifted compare-and-subtract per reduce cycle.
  assign div_sh = 64'(SLOTS) << sh;
  assign rem_sub = rem - div_sh[31:0];
  assign ptr_inc = (32'(ptr) == 32'(SLOTS - 1)) ? '0 : ptr + AW'(1);
  assign wr_addr = (cmd.wr_ins && have_tomb) ? tomb : ptr;
  assign we_key = cmd.wr_ins || cmd.wr_del;
  assign we_val = cmd.wr_ins || cmd.wr_upd || cmd.wr_del;

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      tombs <= '0;
      live_count <= '0;
    end else begin
      if (cmd.wr_ins) begin
        live[wr_addr] <= 1'b1;
        tombs[wr_addr] <= 1'b0;
        live_count <= live_count + CW'(1);
      end
      if (cmd.wr_del) begin
        live[ptr] <= 1'b0;
        tombs[ptr] <= 1'b1;
        live_count <= live_count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r <= req;
      key <= {req.name_high, req.name_low};
      too_long <= (req.name_length > MAX_LEN);
      len <= req.name_length;
      idx <= '0;
    end
    // Byte scan: zero everything from the terminator or length on.
    if (cmd.trim_step && !sts.trim_done) begin
      if (idx >= len || cur_byte == 8'd0) begin
        key[idx*8 +: 8] <= 8'd0;
        len <= (idx < len) ? idx : len;
      end
      idx <= idx + LW'(1);
    end
    if (cmd.trim_step && sts.trim_done) begin
      idx <= '0;
      hash <= FNV_BASIS;
    end
    if (cmd.hash_step && idx < len) begin
      hash <= hash_x * FNV_PRIME;
      idx <= idx + LW'(1);
    end
    if (cmd.home) begin
      if ((SLOTS & (SLOTS - 1)) == 0) begin
        rem <= hash & 32'(SLOTS - 1);
      end else begin
        rem <= hash;
      end
      sh <= 5'd31;
      have_tomb <= 1'b0;
      visited <= '0;
    end
    if (cmd.reduce) begin
      if (rem >= 32'(SLOTS)) begin
        if (64'(rem) >= div_sh) begin
          rem <= rem_sub;
        end
        sh <= sh - 5'd1;
      end else begin
        ptr <= rem[AW-1:0];
      end
    end
    if (cmd.note_tomb) begin
      have_tomb <= 1'b1;
      tomb <= ptr;
    end
    if (cmd.rd) begin
      visited <= visited + CW'(1);
    end
    if (cmd.advance) begin
      ptr <= ptr_inc;
    end
    if (cmd.set_rsp) begin
      rsp_status <= cmd.rsp_status;
      rsp_value <= cmd.rsp_found ? rd_value : 64'd0;
    end
  end

  // Live count is updated at the same edge as the response latch.
  always_comb begin
    rsp.status = rsp_status;
    rsp.found_value = rsp_value;
    rsp.live_entries = 7'(live_count);
  end

  hkv_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_klo (
    .clk(clk), .we(we_key), .waddr(wr_addr),
    .wdata(cmd.wr_del ? 64'd0 : key[63:0]), .raddr(ptr), .rdata(rd_klo)
  );
  hkv_ram #(.WIDTH(56), .DEPTH(SLOTS)) u_khi (
    .clk(clk), .we(we_key), .waddr(wr_addr),
    .wdata(cmd.wr_del ? 56'd0 : key[119:64]), .raddr(ptr), .rdata(rd_khi)
  );
  hkv_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_val (
    .clk(clk), .we(we_val), .waddr(wr_addr),
    .wdata(cmd.wr_del ? 64'd0 : r.value), .raddr(ptr), .rdata(rd_value)
  );

  always_comb begin
    sts.func = r.func;
    sts.value_zero = (r.value == 64'd0);
    sts.too_long = too_long;
    sts.full = (32'(live_count) >= 32'(SLOTS));
    sts.trim_done = too_long || (32'(idx) >= 32'(SCAN_BYTES));
    sts.hash_done = !(idx < len);
    sts.reduce_done = (rem < 32'(SLOTS));
    sts.slot_live = live[ptr];
    sts.slot_tomb = tombs[ptr];
    sts.key_match = (rd_klo == key[63:0]) && (rd_khi == key[119:64]);
    sts.have_tomb = have_tomb;
    sts.probe_done = (32'(visited) >= 32'(SLOTS));
  end
endmodule

>>> design/hashed_key_value_table_linear_probe.sv
// Open-addressed key/value table, one request word in and one response word
// out. The key (up to KEY_BYTES-1 bytes, cut at the first zero byte) is
// trimmed one byte a cycle over all 15 name bytes, hashed with 32-bit
// FNV-1a one byte a cycle, reduced to a home slot (a mask when SLOTS is a
// power of two, restoring subtraction otherwise), then probed linearly in
// three steps per slot (read issue, RAM read, compare). Requests refused
// early (an insert with a zero value or a full table, a name that is too
// long or an unknown function) skip the hash and the probe. Only one
// request is in flight; the next word is accepted the cycle after the
// response word has left. Key and value storage are RAMs with one write
// and one registered read port; live and tombstone flags are flip-flops
// cleared by reset, so no clearing pass is needed.
module hashed_key_value_table_linear_probe #(
  parameter int SLOTS = 64,
  parameter int KEY_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hkv_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hkv_pkg::rsp_t out_data
);
  import hkv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hkv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  hkv_dp #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES)) u_dp (
    .clk(clk), .rst(rst), .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
  );
endmodule

>>> design/hkv_checker.sv
`include "hashed_key_value_table_linear_probe_macros.svh"
module hkv_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input hkv_pkg::req_t in_data,
  input logic          out_valid,
  input logic          out_stall,
  input hkv_pkg::rsp_t out_data
);
  import hkv_pkg::*;

  `HKV_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "out held")
  `HKV_ASSERT(a_one_out, in_valid && !in_stall |=> !out_valid, "early response")
  `HKV_ASSERT(a_busy, out_valid |-> in_stall, "accept while response pending")
  `HKV_ASSERT(a_status, out_valid |-> out_data.status <= ST_NULL, "bad status")
  `HKV_ASSERT_ALWAYS(a_rst, rst |=> !out_valid, "valid after reset")
endmodule

bind hashed_key_value_table_linear_probe hkv_checker u_chk (.*);
